// File: rtl/tcr_pkg.sv
// Shared types, constants and helper functions of the triangle coverage rasteriser.
package tcr_pkg;

	localparam int FRAC_BITS    = 6;
	localparam int ONE          = 1 << FRAC_BITS;
	localparam int MAX_COLUMNS  = 64;
	localparam int MAX_ROWS     = 64;
	localparam int COL_CAP      = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;
	localparam int ROW_CAP      = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int ROW_DIV_BITS = 8;
	localparam int ROW_DIV      = 1 << ROW_DIV_BITS;

	localparam int VERT_W       = 16;
	localparam int COORD_W      = 17;
	localparam int EDGE_W       = 17;
	localparam int QW           = 18;
	localparam int ACC_W        = 40;
	localparam int RACC_W       = 28;
	localparam int MASK_W       = 64;
	localparam int MASK_IDX_W   = 6;
	localparam int COL_W        = 6;
	localparam int FILL_W       = 8;

	localparam int DIM_W        = 7;
	localparam int SCALE_W      = 9;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;

	localparam int IN_W         = 104;
	localparam int OUT_W        = 80;

	localparam logic [DIM_W-1:0]   COLUMNS_RESET = 7'd50;
	localparam logic [DIM_W-1:0]   ROWS_RESET    = 7'd50;
	localparam logic [SCALE_W-1:0] SCALE_RESET   = 9'd115;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS = 2'd0,
		REG_ROWS    = 2'd1,
		REG_SCALE   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic en;
		logic first;
		logic sub;
	} mac_ctl_t;

	function automatic logic signed [COORD_W-1:0] trunc_frac(
		input logic signed [VERT_W-1:0] v);
		logic signed [COORD_W-1:0] w;
		w = COORD_W'(v);
		if (w < 0) w = w + COORD_W'(ONE - 1);
		return w >>> FRAC_BITS;
	endfunction

	function automatic logic signed [COORD_W-1:0] min3(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic signed [COORD_W-1:0] c);
		logic signed [COORD_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [COORD_W-1:0] max3(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic signed [COORD_W-1:0] c);
		logic signed [COORD_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic signed [RACC_W-1:0] row_of(
		input logic signed [RACC_W-1:0] racc);
		logic signed [RACC_W-1:0] w;
		w = racc;
		if (w < 0) w = w + RACC_W'(ROW_DIV - 1);
		return w >>> ROW_DIV_BITS;
	endfunction

endpackage

// File: rtl/triangle_coverage_raster.sv
// Top level: triangle coverage rasteriser, one pixel test per cycle over the clipped box.
// Set-up runs bounds, origin, seven products on the shared multiplier, then load.
// Each visible column sweeps rows from max(min_y, -255), or min_y at zero row scale, up to
// max_y while the scaled row stays below the row limit; no rows are swept if det is 0.
// No visible column: origin goes straight to emit. Ready only while idle; one item at a time.
// Reset: asynchronous, active low; registers return to 50 / 50 / 115 and the block idles.
module triangle_coverage_raster
	import tcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // ax, ay, bx, by, cx, cy, fill_code
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // column, row_mask, fill_code_out, zero pad
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_BOUND  = 8'b0000_0010,
		ST_ORIGIN = 8'b0000_0100,
		ST_MUL    = 8'b0000_1000,
		ST_LOAD   = 8'b0001_0000,
		ST_COL    = 8'b0010_0000,
		ST_ROW    = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	localparam logic [2:0] MS_DET_A = 3'd0;
	localparam logic [2:0] MS_DET_B = 3'd1;
	localparam logic [2:0] MS_S_A   = 3'd2;
	localparam logic [2:0] MS_S_B   = 3'd3;
	localparam logic [2:0] MS_T_A   = 3'd4;
	localparam logic [2:0] MS_T_B   = 3'd5;
	localparam logic [2:0] MS_ROW   = 3'd6;

	localparam logic signed [COORD_W-1:0] Y_FLOOR = COORD_W'(1 - ROW_DIV);

	state_t state_q;
	logic [2:0] step_q;

	logic [DIM_W-1:0]   cols_q;
	logic [DIM_W-1:0]   rows_q;
	logic [SCALE_W-1:0] scale_q;

	logic signed [VERT_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [FILL_W-1:0] fill_q;

	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [EDGE_W-1:0]  e1x_q, e1y_q, e2x_q, e2y_q;
	logic signed [COORD_W-1:0] x_q, x_end_q, y_start_q, y_q;
	logic signed [QW-1:0]      qx0_q, qy0_q;
	logic signed [ACC_W-1:0]   det_q, s_col_q, t_col_q, s_q, t_q;
	logic signed [ACC_W-1:0]   ds_y_q, dt_y_q, ds_x_q, dt_x_q;
	logic signed [RACC_W-1:0]  racc0_q, racc_q;
	logic [MASK_W-1:0]         mask_q;

	logic                 out_valid_q;
	logic [COL_W-1:0]     out_col_q;
	logic [MASK_W-1:0]    out_mask_q;
	logic [FILL_W-1:0]    out_fill_q;
	logic                 out_last_q;

	mac_ctl_t                mac_ctl;
	logic signed [QW-1:0]    mac_a, mac_b;
	logic signed [ACC_W-1:0] mac_acc;

	logic [DIM_W-1:0]          col_lim, row_lim;
	logic signed [COORD_W-1:0] x_lim, x_start, x_end, y_start;
	logic                      visible;
	logic signed [QW-1:0]      qx0, qy0;
	logic signed [RACC_W-1:0]  r, row_lim_s;
	logic signed [ACC_W-1:0]   st;
	logic                      col_done, covered, take_req, load_out, last_col;

	tcr_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (mac_acc)
	);

	always_comb begin
		col_lim = (cols_q > DIM_W'(COL_CAP)) ? DIM_W'(COL_CAP) : cols_q;
		row_lim = (rows_q > DIM_W'(ROW_CAP)) ? DIM_W'(ROW_CAP) : rows_q;
		x_lim   = COORD_W'(col_lim) - COORD_W'(1);
		x_start = (min_x_q < 0) ? '0 : min_x_q;
		x_end   = (max_x_q < x_lim) ? max_x_q : x_lim;
		visible = (x_start <= x_end);
		y_start = ((scale_q != '0) && (min_y_q < Y_FLOOR)) ? Y_FLOOR : min_y_q;
		qx0     = (QW'(x_start) <<< FRAC_BITS) - QW'(ax_q);
		qy0     = (QW'(y_start) <<< FRAC_BITS) - QW'(ay_q);
	end

	always_comb begin
		mac_ctl.en    = (state_q == ST_MUL);
		mac_ctl.first = ~step_q[0];
		mac_ctl.sub   = step_q[0];
		mac_a = '0;
		mac_b = '0;
		case (step_q)
			MS_DET_A: begin mac_a = QW'(e1x_q); mac_b = QW'(e2y_q); end
			MS_DET_B: begin mac_a = QW'(e1y_q); mac_b = QW'(e2x_q); end
			MS_S_A:   begin mac_a = qx0_q;      mac_b = QW'(e2y_q); end
			MS_S_B:   begin mac_a = qy0_q;      mac_b = QW'(e2x_q); end
			MS_T_A:   begin mac_a = QW'(e1x_q); mac_b = qy0_q;      end
			MS_T_B:   begin mac_a = QW'(e1y_q); mac_b = qx0_q;      end
			MS_ROW:   begin mac_a = QW'(y_start_q); mac_b = QW'(scale_q); end
			default:  begin mac_a = '0;         mac_b = '0;         end
		endcase
	end

	always_comb begin
		r         = row_of(racc_q);
		row_lim_s = RACC_W'(row_lim);
		st        = s_q + t_q;
		col_done  = (det_q == '0) || (y_q > max_y_q) || (r >= row_lim_s);
		if (!det_q[ACC_W-1]) begin
			covered = (s_q >= 0) && (t_q >= 0) && (st <= det_q);
		end else begin
			covered = (s_q <= 0) && (t_q <= 0) && (st >= det_q);
		end
		take_req = s_tvalid && (state_q == ST_IDLE);
		load_out = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
		last_col = (x_q == x_end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= MS_DET_A;
			out_valid_q <= 1'b0;
			cols_q      <= COLUMNS_RESET;
			rows_q      <= ROWS_RESET;
			scale_q     <= SCALE_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLUMNS: cols_q  <= cfg_data[DIM_W-1:0];
					REG_ROWS:    rows_q  <= cfg_data[DIM_W-1:0];
					REG_SCALE:   scale_q <= cfg_data[SCALE_W-1:0];
					default:     ;
				endcase
			end

			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE:   if (take_req) state_q <= ST_BOUND;
				ST_BOUND:  state_q <= ST_ORIGIN;
				ST_ORIGIN: begin
					step_q  <= MS_DET_A;
					state_q <= visible ? ST_MUL : ST_EMIT;
				end
				ST_MUL: begin
					if (step_q == MS_ROW) state_q <= ST_LOAD;
					else step_q <= step_q + 3'd1;
				end
				ST_LOAD:   state_q <= ST_COL;
				ST_COL:    state_q <= ST_ROW;
				ST_ROW:    if (col_done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load_out) state_q <= last_col ? ST_IDLE : ST_COL;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			ax_q   <= s_tdata[15:0];
			ay_q   <= s_tdata[31:16];
			bx_q   <= s_tdata[47:32];
			by_q   <= s_tdata[63:48];
			cx_q   <= s_tdata[79:64];
			cy_q   <= s_tdata[95:80];
			fill_q <= s_tdata[103:96];
		end

		if (state_q == ST_BOUND) begin
			min_x_q <= min3(trunc_frac(ax_q), trunc_frac(bx_q), trunc_frac(cx_q));
			max_x_q <= max3(trunc_frac(ax_q), trunc_frac(bx_q), trunc_frac(cx_q));
			min_y_q <= min3(trunc_frac(ay_q), trunc_frac(by_q), trunc_frac(cy_q));
			max_y_q <= max3(trunc_frac(ay_q), trunc_frac(by_q), trunc_frac(cy_q));
			e1x_q   <= EDGE_W'(bx_q) - EDGE_W'(ax_q);
			e1y_q   <= EDGE_W'(by_q) - EDGE_W'(ay_q);
			e2x_q   <= EDGE_W'(cx_q) - EDGE_W'(ax_q);
			e2y_q   <= EDGE_W'(cy_q) - EDGE_W'(ay_q);
		end

		if (state_q == ST_ORIGIN) begin
			// hold an empty, last result when no column survives clipping
			x_q       <= visible ? x_start : '0;
			x_end_q   <= visible ? x_end : '0;
			mask_q    <= '0;
			y_start_q <= y_start;
			qx0_q     <= qx0;
			qy0_q     <= qy0;
			ds_y_q    <= -(ACC_W'(e2x_q) <<< FRAC_BITS);
			dt_y_q    <= ACC_W'(e1x_q) <<< FRAC_BITS;
			ds_x_q    <= ACC_W'(e2y_q) <<< FRAC_BITS;
			dt_x_q    <= -(ACC_W'(e1y_q) <<< FRAC_BITS);
		end

		if (state_q == ST_MUL) begin
			if (step_q == MS_S_A) det_q <= mac_acc;
			if (step_q == MS_T_A) s_col_q <= mac_acc;
			if (step_q == MS_ROW) t_col_q <= mac_acc;
		end

		if (state_q == ST_LOAD) racc0_q <= mac_acc[RACC_W-1:0];

		if (state_q == ST_COL) begin
			s_q    <= s_col_q;
			t_q    <= t_col_q;
			y_q    <= y_start_q;
			racc_q <= racc0_q;
			mask_q <= '0;
		end

		if ((state_q == ST_ROW) && !col_done) begin
			if (covered && (r >= 0)) mask_q[r[MASK_IDX_W-1:0]] <= 1'b1;
			s_q    <= s_q + ds_y_q;
			t_q    <= t_q + dt_y_q;
			racc_q <= racc_q + RACC_W'(scale_q);
			y_q    <= y_q + COORD_W'(1);
		end

		if (load_out) begin
			out_col_q  <= x_q[COL_W-1:0];
			out_mask_q <= mask_q;
			out_fill_q <= fill_q;
			out_last_q <= last_col;
			if (!last_col) begin
				x_q     <= x_q + COORD_W'(1);
				s_col_q <= s_col_q + ds_x_q;
				t_col_q <= t_col_q + dt_x_q;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - COL_W - MASK_W - FILL_W){1'b0}}, out_fill_q, out_mask_q, out_col_q};
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/tcr_mac.sv
// Shared signed multiply-accumulate unit used for the edge and row set-up products.
module tcr_mac
	import tcr_pkg::*;
(
	input  logic                    clk,
	input  mac_ctl_t                ctl,
	input  logic signed [QW-1:0]    a,
	input  logic signed [QW-1:0]    b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*QW-1:0]  prod;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_q;

	always_comb begin
		prod = a * b;
		term = ctl.sub ? -ACC_W'(prod) : ACC_W'(prod);
		base = ctl.first ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) acc_q <= base + term;
	end

	assign acc = acc_q;

endmodule

// File: tb/triangle_coverage_raster_test.sv
// Self-checking testbench for the triangle coverage rasteriser: directed and random triangles.
`timescale 1ns / 1ps

module triangle_coverage_raster_test
	import tcr_pkg::*;
();

	localparam int HOLD_OFF_CYCLES = 600;
	localparam int SETTLE_CYCLES   = 16;
	localparam int PHASE_ITEMS     = 16;
	localparam int N_SHAPES        = 15;
	localparam int N_WINDOWS       = 8;

	typedef struct packed {
		logic [FILL_W-1:0]        fill;
		logic signed [VERT_W-1:0] cy;
		logic signed [VERT_W-1:0] cx;
		logic signed [VERT_W-1:0] by;
		logic signed [VERT_W-1:0] bx;
		logic signed [VERT_W-1:0] ay;
		logic signed [VERT_W-1:0] ax;
	} triangle_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [MASK_W-1:0] row_mask;
		logic [FILL_W-1:0] fill;
		logic              last;
	} coverage_t;

	typedef struct {
		int ax, ay, bx, by, cx, cy, fill;
		bit typed;
		int col;
	} shape_row_t;

	// typed rows expect a single empty mask marked last at the given column
	shape_row_t shape_table [N_SHAPES] = '{
		'{-32768, -32768, -32768, -32768, -32768, -32768, 0, 1'b1, 0},
		'{32767, 32767, 32767, 32767, 32767, 32767, 255, 1'b1, 0},
		'{640, 640, 640, 640, 640, 640, 90, 1'b1, 10},
		'{0, 0, 320, 320, 640, 640, 165, 1'b0, 0},
		'{0, 0, 1280, 0, 0, 1280, 42, 1'b0, 0},
		'{0, 0, 0, 1280, 1280, 0, 213, 1'b0, 0},
		'{128, -192, 640, -192, 384, 320, 17, 1'b0, 0},
		'{-63, -63, 700, -63, -63, 700, 34, 1'b0, 0},
		'{2560, 640, 3840, 640, 3200, 1920, 51, 1'b0, 0},
		'{640, 6400, 1920, 6400, 1280, 8320, 68, 1'b0, 0},
		'{-32768, -32768, 32767, -32768, 0, 32767, 129, 1'b0, 0},
		'{32767, 32767, -32768, 32767, 0, -32768, 126, 1'b0, 0},
		'{3136, 0, 3200, 0, 3200, 640, 195, 1'b0, 0},
		'{-64, 0, 64, 0, 0, 640, 60, 1'b0, 0},
		'{640, 640, 704, 640, 640, 704, 170, 1'b0, 0}
	};

	// columns, rows, row scale; the last setting is drawn at random
	int window_plan [N_WINDOWS][3] = '{
		'{64, 64, 256}, '{1, 1, 1}, '{127, 127, 511}, '{0, 0, 0},
		'{64, 64, 128}, '{20, 40, 200}, '{50, 50, 115}, '{0, 0, 0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [DIM_W-1:0]   columns_now;
	logic [DIM_W-1:0]   rows_now;
	logic [SCALE_W-1:0] scale_now;

	coverage_t coverage_due [$];
	bit        hold_off_req;
	bit        steady;
	int        err_count;
	int        masks_seen;
	int        triangles_sent;
	int        degenerate_sent;

	triangle_coverage_raster u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic void raster_triangle(input triangle_t t);
		longint ax, ay, bx, by, cx, cy;
		longint lo_x, hi_x, lo_y, hi_y, col_lim, row_lim, scale;
		longint e1x, e1y, e2x, e2y, det, qx, qy, s, u, r;
		logic [MASK_W-1:0] mask;
		bit hit;
		int n;
		coverage_t c;
		ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
		lo_x = ax < bx ? ax : bx;
		lo_x = (lo_x < cx ? lo_x : cx) / ONE;
		hi_x = ax > bx ? ax : bx;
		hi_x = (hi_x > cx ? hi_x : cx) / ONE;
		lo_y = ay < by ? ay : by;
		lo_y = (lo_y < cy ? lo_y : cy) / ONE;
		hi_y = ay > by ? ay : by;
		hi_y = (hi_y > cy ? hi_y : cy) / ONE;
		col_lim = longint'(columns_now);
		row_lim = longint'(rows_now);
		if (col_lim > COL_CAP) col_lim = COL_CAP;
		if (row_lim > ROW_CAP) row_lim = ROW_CAP;
		scale = longint'(scale_now);
		e1x = bx - ax; e1y = by - ay;
		e2x = cx - ax; e2y = cy - ay;
		det = e1x * e2y - e1y * e2x;
		n = 0;
		for (longint x = lo_x; x <= hi_x; x++) begin
			if (x < 0 || x >= col_lim) continue;
			mask = '0;
			if (det != 0) begin
				for (longint y = lo_y; y <= hi_y; y++) begin
					qx = x * ONE - ax;
					qy = y * ONE - ay;
					s = qx * e2y - qy * e2x;
					u = e1x * qy - e1y * qx;
					if (det > 0) hit = s >= 0 && u >= 0 && s + u <= det;
					else hit = s <= 0 && u <= 0 && s + u >= det;
					if (!hit) continue;
					r = (y * scale) / ROW_DIV;
					if (r >= 0 && r < row_lim) mask[r[MASK_IDX_W-1:0]] = 1'b1;
				end
			end
			c.column = x[COL_W-1:0];
			c.row_mask = mask;
			c.fill = t.fill;
			c.last = (x == hi_x) || (x == col_lim - 1);
			coverage_due.push_back(c);
			n++;
		end
		if (n == 0) coverage_due.push_back('{'0, '0, t.fill, 1'b1});
	endfunction

	task automatic offer_triangle(input triangle_t t, input bit typed, input int col);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		triangles_sent++;
		if (typed) coverage_due.push_back('{COL_W'(col), '0, t.fill, 1'b1});
		else raster_triangle(t);
	endtask

	task automatic await_idle();
		s_tvalid <= 1'b0;
		while (coverage_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input int cols, input int rows, input int scale);
		cfg_we <= 1'b1;
		cfg_index <= REG_COLUMNS;
		cfg_data <= CFG_DATA_W'(cols);
		@(posedge clk);
		cfg_index <= REG_ROWS;
		cfg_data <= CFG_DATA_W'(rows);
		@(posedge clk);
		cfg_index <= REG_SCALE;
		cfg_data <= CFG_DATA_W'(scale);
		@(posedge clk);
		cfg_we <= 1'b0;
		columns_now = DIM_W'(cols);
		rows_now = DIM_W'(rows);
		scale_now = SCALE_W'(scale);
	endtask

	task automatic make_triangle(output triangle_t t);
		int kind, px, py, dx, dy, k1, k2;
		kind = $urandom_range(0, 99);
		t.fill = FILL_W'($urandom_range(0, 255));
		if (kind < 60) begin
			t.ax = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
			t.ay = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
			t.bx = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
			t.by = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
			t.cx = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
			t.cy = VERT_W'($urandom_range(0, 76 * ONE) - 6 * ONE);
		end else if (kind < 82) begin
			px = $urandom_range(0, 72 * ONE) - 4 * ONE;
			py = $urandom_range(0, 72 * ONE) - 4 * ONE;
			t.ax = VERT_W'(px);
			t.ay = VERT_W'(py);
			t.bx = VERT_W'(px + $urandom_range(0, 20 * ONE) - 10 * ONE);
			t.by = VERT_W'(py + $urandom_range(0, 20 * ONE) - 10 * ONE);
			t.cx = VERT_W'(px + $urandom_range(0, 20 * ONE) - 10 * ONE);
			t.cy = VERT_W'(py + $urandom_range(0, 20 * ONE) - 10 * ONE);
		end else if (kind < 96) begin
			px = $urandom_range(0, 70 * ONE) - 3 * ONE;
			py = $urandom_range(0, 70 * ONE) - 3 * ONE;
			dx = $urandom_range(0, 8 * ONE) - 4 * ONE;
			dy = $urandom_range(0, 8 * ONE) - 4 * ONE;
			k1 = $urandom_range(0, 3);
			k2 = $urandom_range(0, 3);
			t.ax = VERT_W'(px);
			t.ay = VERT_W'(py);
			t.bx = VERT_W'(px + k1 * dx);
			t.by = VERT_W'(py + k1 * dy);
			t.cx = VERT_W'(px + k2 * dx);
			t.cy = VERT_W'(py + k2 * dy);
			degenerate_sent++;
		end else begin
			t.ax = VERT_W'($urandom);
			t.ay = VERT_W'($urandom);
			t.bx = VERT_W'($urandom);
			t.by = VERT_W'($urandom);
			t.cx = VERT_W'($urandom);
			t.cy = VERT_W'($urandom);
		end
	endtask

	task automatic check_mask();
		coverage_t want, got;
		got.column = m_tdata[COL_W-1:0];
		got.row_mask = m_tdata[COL_W +: MASK_W];
		got.fill = m_tdata[COL_W + MASK_W +: FILL_W];
		got.last = m_tlast;
		masks_seen++;
		if (coverage_due.size() == 0) begin
			$error("mask for column %0d arrived with no triangle pending", got.column);
			err_count++;
		end else begin
			want = coverage_due.pop_front();
			if (got.column !== want.column) begin
				$error("column: expected %0d, got %0d", want.column, got.column);
				err_count++;
			end
			if (got.row_mask !== want.row_mask) begin
				$error("row_mask: expected %h, got %h", want.row_mask, got.row_mask);
				err_count++;
			end
			if (got.fill !== want.fill) begin
				$error("fill_code_out: expected %0d, got %0d", want.fill, got.fill);
				err_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				err_count++;
			end
		end
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_mask();
		end
	end

	initial begin
		triangle_t t;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		columns_now = COLUMNS_RESET;
		rows_now = ROWS_RESET;
		scale_now = SCALE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (shape_table[i]) begin
			t.ax = VERT_W'(shape_table[i].ax);
			t.ay = VERT_W'(shape_table[i].ay);
			t.bx = VERT_W'(shape_table[i].bx);
			t.by = VERT_W'(shape_table[i].by);
			t.cx = VERT_W'(shape_table[i].cx);
			t.cy = VERT_W'(shape_table[i].cy);
			t.fill = FILL_W'(shape_table[i].fill);
			offer_triangle(t, shape_table[i].typed, shape_table[i].col);
		end
		await_idle();

		for (int p = 0; p < N_WINDOWS; p++) begin
			if (p == N_WINDOWS - 1) begin
				window_plan[p][0] = $urandom_range(1, 64);
				window_plan[p][1] = $urandom_range(1, 64);
				window_plan[p][2] = $urandom_range(1, 256);
			end
			hold_off_req = (p == 0);
			steady = (p == 3) || (p == 5);
			set_window(window_plan[p][0], window_plan[p][1], window_plan[p][2]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				make_triangle(t);
				offer_triangle(t, 1'b0, 0);
			end
			await_idle();
		end

		$display("Rasterised %0d triangles (%0d degenerate) over %0d window settings;",
			triangles_sent, degenerate_sent, N_WINDOWS + 1);
		$display("compared %0d coverage masks, including a %0d-cycle output hold-off.",
			masks_seen, HOLD_OFF_CYCLES);
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
